### rtl/acws_pkg.sv
// Shared types, constants and time-wrap function for the alarm clock block.
package acws_pkg;

	localparam int NUM_BUTTONS = 8;

	localparam logic [7:0]  DIV_RESET    = 8'd128;
	localparam logic [7:0]  SNOOZE_RESET = 8'd10;
	localparam logic [4:0]  ALARM_H_RESET = 5'd12;
	localparam logic [15:0] DEB_FORCE    = 16'hE000;
	localparam logic [15:0] DEB_PRESS    = 16'hFF00;
	localparam logic [1:0]  PH_DETENT    = 2'b11;
	localparam logic [1:0]  PH_UP        = 2'b01;
	localparam logic [1:0]  PH_DOWN      = 2'b10;
	localparam logic [5:0]  SEC_MAX      = 6'd59;
	localparam logic [5:0]  MIN_MAX      = 6'd59;
	localparam logic [4:0]  HOUR_MAX     = 5'd23;

	localparam int BTN_SNOOZE = 4;
	localparam int BTN_ARM    = 5;
	localparam int BTN_ALARM  = 6;
	localparam int BTN_TIME   = 7;

	typedef enum logic [0:0] {
		REG_TICK_DIVIDER   = 1'b0,
		REG_SNOOZE_SECONDS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_TICK   = 1'b0,
		KIND_BUTTON = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] encoder_bits;
		logic [7:0] button_pins;
	} item_t;

	typedef struct packed {
		logic [4:0] clock_hours;
		logic [5:0] clock_minutes;
		logic [5:0] clock_seconds;
		logic [4:0] alarm_hours_out;
		logic [5:0] alarm_minutes_out;
		logic       alarm_enabled;
		logic       alarm_sounding;
		logic       snooze_active;
		logic       editing_time;
		logic       editing_alarm;
		logic       colon_on;
	} result_t;

	typedef struct packed {
		logic up;
		logic dn;
	} step_t;

	typedef struct packed {
		logic [4:0] h;
		logic [5:0] m;
	} hm_t;

	function automatic hm_t hm_adjust(input logic [4:0] h, input logic [5:0] m,
			input step_t dh, input step_t dm);
		logic signed [7:0] hv;
		logic signed [7:0] mv;
		hm_t r;
		hv = $signed({3'b000, h});
		mv = $signed({2'b00, m});
		if (dh.up) hv = hv + 8'sd1;
		if (dh.dn) hv = hv - 8'sd1;
		if (dm.up) mv = mv + 8'sd1;
		if (dm.dn) mv = mv - 8'sd1;
		if (mv > $signed({2'b00, MIN_MAX})) begin
			mv = 8'sd0;
			hv = hv + 8'sd1;
			if (hv > $signed({3'b000, HOUR_MAX})) hv = 8'sd0;
		end
		if (hv > $signed({3'b000, HOUR_MAX})) hv = 8'sd0;
		if (hv < 8'sd0) hv = $signed({3'b000, HOUR_MAX});
		if (mv < 8'sd0) begin
			mv = $signed({2'b00, MIN_MAX});
			hv = hv - 8'sd1;
			if (hv < 8'sd0) hv = $signed({3'b000, HOUR_MAX});
		end
		r.h = hv[4:0];
		r.m = mv[5:0];
		return r;
	endfunction

endpackage

### rtl/alarm_clock_with_snooze_and_encoders_unit.sv
// Top level of the alarm clock: timekeeping, lane merge, alarm rules, output buffer.
// An accepted transaction's result is registered into the output register or the skid.
// Throughput: one transaction per cycle while item_stall is low; the whole state update
// of an item is combinational logic after eight debounce lanes and two encoder lanes.
// A two-entry output buffer (output register plus skid) keeps input flowing in a stall
// until the skid fills. Reset is asynchronous and active low; all state returns to the
// power-up time 00:00:00, alarm 12:00, divider 128, snooze 10, no buffered results.
module alarm_clock_with_snooze_and_encoders_unit import acws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] div_q, snooze_len_q;
	logic [7:0] tick_q, snz_cnt_q;
	logic [5:0] sec_q, min_q, amin_q;
	logic [4:0] hour_q, ahour_q;
	logic       armed_q, sound_q, snooze_q, edt_q, eda_q, colon_q, primed_q;

	logic       acc_in, acc_out, out_free;
	logic       tick_en, btn_en;
	logic [NUM_BUTTONS-1:0] press;
	step_t      step_l, step_r, no_step, st_h, st_m;

	logic [7:0] tick_n, tc, snz_n;
	logic [5:0] sec_n, min_n, amin_n, sec_inc, min_inc;
	logic [4:0] hour_n, ahour_n, hour_inc;
	logic       armed_n, sound_n, snooze_n, edt_n, eda_n, colon_n, fire;
	hm_t        clk_hm, alm_hm;
	result_t    res_n;

	logic       out_valid_q, skid_valid_q;
	result_t    out_q, skid_q;

	assign cfg_ready  = 1'b1;
	assign item_stall = skid_valid_q;
	assign acc_in     = item_valid && !skid_valid_q;
	assign acc_out    = out_valid_q && !result_stall;
	assign out_free   = !out_valid_q || acc_out;
	assign tick_en    = acc_in && (item.kind == KIND_TICK);
	assign btn_en     = acc_in && (item.kind == KIND_BUTTON);

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_deb
		acws_deb_lane u_deb (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (btn_en),
			.pin   (item.button_pins[b]),
			.press (press[b])
		);
	end

	acws_enc_lane u_enc_l (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (tick_en),
		.primed(primed_q),
		.phase (item.encoder_bits[1:0]),
		.step  (step_l)
	);

	acws_enc_lane u_enc_r (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (tick_en),
		.primed(primed_q),
		.phase (item.encoder_bits[3:2]),
		.step  (step_r)
	);

	assign no_step = '0;
	assign st_h    = edt_q ? step_l : no_step;
	assign st_m    = edt_q ? step_r : no_step;

	always_comb begin
		tc       = tick_q + 8'd1;
		fire     = (tc == div_q);
		sec_inc  = sec_q;
		min_inc  = min_q;
		hour_inc = hour_q;
		colon_n  = colon_q;
		snz_n    = snz_cnt_q;
		if (fire) begin
			colon_n = !colon_q;
			if (sec_q >= SEC_MAX) begin
				sec_inc = '0;
				if (min_q >= MIN_MAX) begin
					min_inc  = '0;
					hour_inc = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
				end else begin
					min_inc = min_q + 6'd1;
				end
			end else begin
				sec_inc = sec_q + 6'd1;
			end
			if (snooze_q) snz_n = snz_cnt_q + 8'd1;
		end
		clk_hm = hm_adjust(hour_inc, min_inc, st_h, st_m);
		alm_hm = hm_adjust(ahour_q, amin_q, eda_q ? step_l : no_step,
			eda_q ? step_r : no_step);

		tick_n  = tick_q;
		sec_n   = sec_q;
		min_n   = min_q;
		hour_n  = hour_q;
		amin_n  = amin_q;
		ahour_n = ahour_q;
		armed_n = armed_q;
		snooze_n = snooze_q;
		edt_n   = edt_q;
		eda_n   = eda_q;
		if (item.kind == KIND_TICK) begin
			tick_n  = fire ? 8'd0 : tc;
			sec_n   = (st_h.up || st_h.dn || st_m.up || st_m.dn) ? 6'd0 : sec_inc;
			min_n   = clk_hm.m;
			hour_n  = clk_hm.h;
			amin_n  = alm_hm.m;
			ahour_n = alm_hm.h;
		end else begin
			colon_n = colon_q;
			snz_n   = snz_cnt_q;
			if (press[BTN_SNOOZE]) snooze_n = !snooze_n;
			if (press[BTN_ARM]) armed_n = !armed_n;
			if (press[BTN_ALARM]) begin
				eda_n = !eda_n;
				edt_n = 1'b0;
			end
			if (press[BTN_TIME]) begin
				edt_n = !edt_n;
				eda_n = 1'b0;
			end
		end

		sound_n = sound_q;
		if (!sound_q) begin
			if (armed_n && (hour_n == ahour_n) && (min_n == amin_n)) sound_n = 1'b1;
		end else if (!armed_n) begin
			sound_n = 1'b0;
		end
		if (snooze_n) sound_n = 1'b0;
		if (snz_n == snooze_len_q) begin
			sound_n  = 1'b1;
			snooze_n = 1'b0;
			snz_n    = '0;
		end

		res_n.clock_hours       = hour_n;
		res_n.clock_minutes     = min_n;
		res_n.clock_seconds     = sec_n;
		res_n.alarm_hours_out   = ahour_n;
		res_n.alarm_minutes_out = amin_n;
		res_n.alarm_enabled     = armed_n;
		res_n.alarm_sounding    = sound_n;
		res_n.snooze_active     = snooze_n;
		res_n.editing_time      = edt_n;
		res_n.editing_alarm     = eda_n;
		res_n.colon_on          = colon_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q        <= DIV_RESET;
			snooze_len_q <= SNOOZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TICK_DIVIDER:   div_q        <= cfg_data;
				REG_SNOOZE_SECONDS: snooze_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			sec_q     <= '0;
			min_q     <= '0;
			hour_q    <= '0;
			ahour_q   <= ALARM_H_RESET;
			amin_q    <= '0;
			armed_q   <= 1'b0;
			sound_q   <= 1'b0;
			snooze_q  <= 1'b0;
			snz_cnt_q <= '0;
			edt_q     <= 1'b0;
			eda_q     <= 1'b0;
			colon_q   <= 1'b1;
			primed_q  <= 1'b0;
		end else if (acc_in) begin
			tick_q    <= tick_n;
			sec_q     <= sec_n;
			min_q     <= min_n;
			hour_q    <= hour_n;
			ahour_q   <= ahour_n;
			amin_q    <= amin_n;
			armed_q   <= armed_n;
			sound_q   <= sound_n;
			snooze_q  <= snooze_n;
			snz_cnt_q <= snz_n;
			edt_q     <= edt_n;
			eda_q     <= eda_n;
			colon_q   <= colon_n;
			if (item.kind == KIND_TICK) primed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= acc_in;
			end else begin
				out_valid_q  <= acc_in;
			end
		end else if (acc_in) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (acc_in) skid_q <= res_n;
			end else if (acc_in) begin
				out_q <= res_n;
			end
		end else if (acc_in) begin
			skid_q <= res_n;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/acws_deb_lane.sv
// One button debounce lane: 16-bit shift history and press detect.
module acws_deb_lane import acws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic pin,
	output logic press
);

	logic [15:0] hist_q;
	logic [15:0] hist_nxt;

	assign hist_nxt = {hist_q[14:0], pin} | DEB_FORCE;
	assign press    = (hist_nxt == DEB_PRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (en) begin
			hist_q <= hist_nxt;
		end
	end

endmodule

### rtl/acws_enc_lane.sv
// One quadrature encoder lane: previous phase and step direction decode.
module acws_enc_lane import acws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       primed,
	input  logic [1:0] phase,
	output step_t      step
);

	logic [1:0] prev_q;
	logic [1:0] prev_eff;

	assign prev_eff = primed ? prev_q : phase;
	assign step.up  = (phase == PH_DETENT) && (prev_eff == PH_UP);
	assign step.dn  = (phase == PH_DETENT) && (prev_eff == PH_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (en) begin
			prev_q <= phase;
		end
	end

endmodule
